### src/ctpd_pkg.sv
package ctpd_pkg;

   localparam int FRAC_BITS_DEF = 4;

   localparam logic [7:0]  HDR_LENGTH  = 8'h09;
   localparam logic [7:0]  HDR_MSG_ID  = 8'h4E;
   localparam logic [7:0]  HDR_CHANNEL = 8'h00;
   localparam logic [7:0]  PAGE_TORQUE = 8'h20;
   localparam logic [15:0] OFFSET_RESET = 16'd507;

   localparam int DIV_W     = 48;
   localparam int DIV_DEN_W = 16;
   localparam int MUL_W     = 40;

   localparam logic [24:0] CAD_SCALE = 25'd120000;
   localparam logic [26:0] FRQ_SCALE = 27'd2000;
   localparam logic [DIV_DEN_W-1:0] POWER_DIVISOR = 16'd30;
   localparam logic [MUL_W-1:0] PI_Q16 = 40'd205887;
   localparam logic [2*MUL_W-1:0] PROD_LIMIT = 80'd30 << 40;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quo;
   } div_rsp_type;

   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic [2*MUL_W-1:0] prod;
   } mul_rsp_type;

endpackage

### src/ctpd_if.sv
interface ctpd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  msg_length;
   logic [7:0]  msg_id;
   logic [7:0]  channel_num;
   logic [7:0]  page_num;
   logic [7:0]  event_count;
   logic [15:0] slope_value;
   logic [15:0] stamp_ticks;
   logic [15:0] torque_tick_count;
   logic [31:0] now_ms;

   modport source (output valid, msg_length, msg_id, channel_num, page_num, event_count,
                   slope_value, stamp_ticks, torque_tick_count, now_ms, input ready);
   modport sink (input valid, msg_length, msg_id, channel_num, page_num, event_count,
                 slope_value, stamp_ticks, torque_tick_count, now_ms, output ready);
endinterface

interface ctpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] power_sixteenths;
   logic [15:0] interval_ticks;
   logic [15:0] cadence_sixteenths;
   logic        coast_out;
   logic        fault;

   modport source (output valid, power_sixteenths, interval_ticks, cadence_sixteenths,
                   coast_out, fault, input ready);
   modport sink (input valid, power_sixteenths, interval_ticks, cadence_sixteenths,
                 coast_out, fault, output ready);
endinterface

interface ctpd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] wdata;

   modport source (output valid, wdata, input ready);
   modport sink (input valid, wdata, output ready);
endinterface

### src/ctpd_div.sv
module ctpd_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ctpd_pkg::div_req_type div_req,
   output ctpd_pkg::div_rsp_type div_rsp
);
   import ctpd_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= div_req.num;
            den_ff  <= div_req.den;
         end else if (busy_ff) begin
            rem_ff <= fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

### src/ctpd_mul.sv
module ctpd_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  ctpd_pkg::mul_req_type mul_req,
   output ctpd_pkg::mul_rsp_type mul_rsp
);
   import ctpd_pkg::*;

   localparam int CNT_W = $clog2(MUL_W);

   logic [MUL_W-1:0]   a_ff;
   logic [MUL_W-1:0]   b_ff;
   logic [2*MUL_W-1:0] prod_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [MUL_W:0]     sum;

   assign sum = {1'b0, prod_ff[2*MUL_W-1:MUL_W]} + (b_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            a_ff    <= mul_req.a;
            b_ff    <= mul_req.b;
            prod_ff <= '0;
         end else if (busy_ff) begin
            prod_ff <= {sum, prod_ff[MUL_W-1:1]};
            b_ff    <= {1'b0, b_ff[MUL_W-1:1]};
            if (cnt_ff == CNT_W'(MUL_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = prod_ff;

endmodule

### src/crank_torque_power_decode.sv
// An item that computes nothing (rejected header, other page, first or repeated torque
// page, or a zero interval or slope, flagged as a fault) goes straight to the output.
// An item that computes power takes at most four passes of the bit-serial divider and
// two passes of the bit-serial multiplier, and then loads the result into the output.
// One item is in work at a time; a new one is taken once the last result is loaded.
// Reset is synchronous and active high: it restores the offset to 507 and clears the
// stored page, the coast state and the last cadence.
module crank_torque_power_decode #(
   parameter int FRAC_BITS = ctpd_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ctpd_req_if.sink    req_bus,
   ctpd_rsp_if.source  rsp_bus,
   ctpd_csr_if.sink    csr_bus
);
   import ctpd_pkg::*;

   localparam int CAD_SHIFT = 8 - FRAC_BITS;
   localparam int PW_SHIFT  = 32 - FRAC_BITS;
   localparam int MAG_W     = 2 * MUL_W - PW_SHIFT;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CAD, ST_FRQ, ST_TRQ, ST_MULP, ST_DIVP, ST_MULPI, ST_OUT
   } state_type;

   state_type   state_ff;

   logic [15:0] offset_ff;
   logic [7:0]  prev_events_ff;
   logic [15:0] prev_stamp_ff;
   logic [15:0] prev_tticks_ff;
   logic        have_prev_ff;
   logic        coast_ff;
   logic [31:0] last_other_ff;
   logic [15:0] last_cad_ff;

   logic [15:0] tint_ff;
   logic [7:0]  dev_ff;
   logic [15:0] dtick_ff;
   logic [15:0] slope_ff;
   logic [32:0] cad8_ff;
   logic [34:0] fmag_ff;
   logic [38:0] tmag_ff;
   logic [39:0] p_ff;
   logic [MAG_W-1:0] mag_ff;
   logic        neg_ff;
   logic        sat_ff;
   logic [15:0] iv_st_ff;
   logic [15:0] cad_st_ff;
   logic        flt_st_ff;
   logic        div_start_ff;
   logic        mul_start_ff;

   logic        rsp_valid_ff;
   logic [19:0] rsp_pw_ff;
   logic [15:0] rsp_iv_ff;
   logic [15:0] rsp_cad_ff;
   logic        rsp_coast_ff;
   logic        rsp_flt_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   logic        hdr_ok;
   logic [32:0] coast_el;
   logic [15:0] coast_t;
   logic [15:0] new_t;
   logic [24:0] cad_base;
   logic [26:0] frq_base;
   logic [38:0] trq_num;
   logic [32:0] cad_shifted;
   logic [34:0] fpos;
   logic [34:0] offq;
   logic [20:0] pw_lim;
   logic [20:0] pw_val;
   logic [19:0] pw_out;
   logic        out_free;

   ctpd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ctpd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign hdr_ok = (req_bus.msg_length == HDR_LENGTH) && (req_bus.msg_id == HDR_MSG_ID)
                   && (req_bus.channel_num == HDR_CHANNEL);
   assign coast_el = {req_bus.now_ms - last_other_ff, 1'b0};
   assign coast_t  = (|coast_el[32:16]) ? 16'hFFFF : coast_el[15:0];
   assign new_t    = coast_ff ? coast_t : req_bus.stamp_ticks - prev_stamp_ff;

   assign cad_base = {17'b0, dev_ff} * CAD_SCALE;
   assign frq_base = {11'b0, dtick_ff} * FRQ_SCALE;
   assign trq_num  = 39'({fmag_ff, 3'b0}) + 39'({fmag_ff, 1'b0});
   assign cad_shifted = div_rsp.quo[32:0] >> CAD_SHIFT;
   assign fpos = div_rsp.quo[34:0];
   assign offq = {11'b0, offset_ff, 8'b0};

   always_comb begin
      div_req.start = div_start_ff;
      div_req.num   = '0;
      div_req.den   = tint_ff;
      case (state_ff)
         ST_CAD: div_req.num = {15'b0, cad_base, 8'b0};
         ST_FRQ: div_req.num = {13'b0, frq_base, 8'b0};
         ST_TRQ: begin
            div_req.num = {9'b0, trq_num};
            div_req.den = slope_ff;
         end
         ST_DIVP: begin
            div_req.num = mul_rsp.prod[DIV_W-1:0];
            div_req.den = POWER_DIVISOR;
         end
         default: div_req.num = '0;
      endcase
   end

   always_comb begin
      mul_req.start = mul_start_ff;
      if (state_ff == ST_MULPI) begin
         mul_req.a = p_ff;
         mul_req.b = PI_Q16;
      end else begin
         mul_req.a = {1'b0, tmag_ff};
         mul_req.b = {7'b0, cad8_ff};
      end
   end

   assign pw_lim = neg_ff ? 21'd524288 : 21'd524287;
   assign pw_val = (sat_ff || (mag_ff > MAG_W'(pw_lim))) ? pw_lim : 21'(mag_ff);
   assign pw_out = neg_ff ? 20'(21'd0 - pw_val) : pw_val[19:0];
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         offset_ff      <= OFFSET_RESET;
         prev_events_ff <= '0;
         prev_stamp_ff  <= '0;
         prev_tticks_ff <= '0;
         have_prev_ff   <= 1'b0;
         coast_ff       <= 1'b0;
         last_other_ff  <= '0;
         last_cad_ff    <= '0;
         div_start_ff   <= 1'b0;
         mul_start_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         if (csr_bus.valid) begin
            offset_ff <= csr_bus.wdata;
         end
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  mag_ff    <= '0;
                  sat_ff    <= 1'b0;
                  neg_ff    <= 1'b0;
                  iv_st_ff  <= '0;
                  cad_st_ff <= '0;
                  flt_st_ff <= 1'b0;
                  state_ff  <= ST_OUT;
                  if (!hdr_ok) begin
                     cad_st_ff <= last_cad_ff;
                  end else if (req_bus.page_num != PAGE_TORQUE) begin
                     last_other_ff <= req_bus.now_ms;
                     coast_ff      <= 1'b1;
                  end else if (!have_prev_ff || (req_bus.stamp_ticks != prev_stamp_ff)) begin
                     prev_events_ff <= req_bus.event_count;
                     prev_stamp_ff  <= req_bus.stamp_ticks;
                     prev_tticks_ff <= req_bus.torque_tick_count;
                     have_prev_ff   <= 1'b1;
                     coast_ff       <= 1'b0;
                     if (have_prev_ff) begin
                        tint_ff  <= new_t;
                        dev_ff   <= req_bus.event_count - prev_events_ff;
                        dtick_ff <= req_bus.torque_tick_count - prev_tticks_ff;
                        slope_ff <= req_bus.slope_value;
                        if ((new_t == '0) || (req_bus.slope_value == '0)) begin
                           flt_st_ff <= 1'b1;
                        end else begin
                           iv_st_ff     <= new_t;
                           div_start_ff <= 1'b1;
                           state_ff     <= ST_CAD;
                        end
                     end
                  end
               end
            end
            ST_CAD: begin
               if (div_rsp.done) begin
                  cad8_ff      <= div_rsp.quo[32:0];
                  cad_st_ff    <= (|cad_shifted[32:16]) ? 16'hFFFF : cad_shifted[15:0];
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_FRQ;
               end
            end
            ST_FRQ: begin
               if (div_rsp.done) begin
                  neg_ff       <= fpos < offq;
                  fmag_ff      <= (fpos < offq) ? offq - fpos : fpos - offq;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_TRQ;
               end
            end
            ST_TRQ: begin
               if (div_rsp.done) begin
                  tmag_ff <= div_rsp.quo[38:0];
                  if ((div_rsp.quo[38:0] == '0) || (cad8_ff == '0)) begin
                     state_ff <= ST_OUT;
                  end else begin
                     mul_start_ff <= 1'b1;
                     state_ff     <= ST_MULP;
                  end
               end
            end
            ST_MULP: begin
               if (mul_rsp.done) begin
                  if (mul_rsp.prod >= PROD_LIMIT) begin
                     sat_ff   <= 1'b1;
                     state_ff <= ST_OUT;
                  end else begin
                     div_start_ff <= 1'b1;
                     state_ff     <= ST_DIVP;
                  end
               end
            end
            ST_DIVP: begin
               if (div_rsp.done) begin
                  p_ff         <= div_rsp.quo[39:0];
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_MULPI;
               end
            end
            ST_MULPI: begin
               if (mul_rsp.done) begin
                  mag_ff   <= MAG_W'(mul_rsp.prod >> PW_SHIFT);
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pw_ff    <= pw_out;
                  rsp_iv_ff    <= iv_st_ff;
                  rsp_cad_ff   <= cad_st_ff;
                  rsp_coast_ff <= coast_ff;
                  rsp_flt_ff   <= flt_st_ff;
                  last_cad_ff  <= cad_st_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.power_sixteenths   = rsp_pw_ff;
   assign rsp_bus.interval_ticks     = rsp_iv_ff;
   assign rsp_bus.cadence_sixteenths = rsp_cad_ff;
   assign rsp_bus.coast_out          = rsp_coast_ff;
   assign rsp_bus.fault              = rsp_flt_ff;

endmodule
